@@ rtl/uss_pkg.sv @@
// Shared codes, coil tables and field widths for the unipolar stepper sequencer.
package uss_pkg;

  // command codes carried in tuser
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_MOVE = 2'd1;
  localparam logic [1:0] CMD_STOP = 2'd2;

  // step mode codes
  localparam logic [1:0] MODE_WAVE = 2'd0;
  localparam logic [1:0] MODE_FULL = 2'd1;
  localparam logic [1:0] MODE_HALF = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_STEP_MODE     = 2'd0;
  localparam logic [1:0] REG_BASE_STEPS    = 2'd1;
  localparam logic [1:0] REG_STEP_INTERVAL = 2'd2;

  localparam int COIL_W     = 4;
  localparam int BASE_W     = 13;
  localparam int INTERVAL_W = 16;
  localparam int MOVE_W     = 16;
  localparam int LEFT_W     = 17;
  localparam int POS_OUT_W  = 13;
  localparam int OUT_DATA_W = 24;

  typedef logic [COIL_W-1:0] coil_t;

  localparam coil_t WAVE_CODES [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
  localparam coil_t FULL_CODES [4] = '{4'h3, 4'h6, 4'hC, 4'h9};
  localparam coil_t HALF_CODES [8] = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

  // coil pattern for a mode and the low three bits of the position
  function automatic coil_t coil_pattern(input logic [1:0] mode, input logic [2:0] pos_lo);
    coil_t pat;
    case (mode)
      MODE_HALF: pat = HALF_CODES[pos_lo];
      MODE_WAVE: pat = WAVE_CODES[pos_lo[1:0]];
      default:   pat = FULL_CODES[pos_lo[1:0]];
    endcase
    return pat;
  endfunction

endpackage

@@ rtl/unipolar_stepper_sequencer.sv @@
// Unipolar stepper sequencer: wave, full and half step coil driver for four coil lines.
// An accepted item's result is registered; the output register is reloaded on the same
// edge it is taken. Throughput: one item per cycle while out_tready is high.
// The state update for each item is a single pass of counter, wrap and table logic.
// Reset: synchronous on rst_n low; coils off, position 0, no steps left, forward,
// full step mode, 2048 steps per revolution, interval 30, output register empty.
module unipolar_stepper_sequencer #(
  parameter int MAX_STEPS_PER_REV = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_addr,
  input  logic [uss_pkg::INTERVAL_W-1:0]    cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [uss_pkg::MOVE_W-1:0]        in_tdata,   // [15:0] step count (signed)
  input  logic [1:0]                        in_tuser,   // [1:0] cmd
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [uss_pkg::OUT_DATA_W-1:0]    out_tdata   // [3:0] coils, [4] busy_res,
                                                        // [17:5] position, [23:18] zero
);
  import uss_pkg::*;

  localparam int POS_W = $clog2(MAX_STEPS_PER_REV) + 1;
  localparam int REV_W = POS_W + 1;
  localparam int CMP_W = (REV_W > BASE_W) ? REV_W : BASE_W;

  // configuration
  logic [1:0]            mode_r;
  logic [BASE_W-1:0]     base_r;
  logic [INTERVAL_W-1:0] interval_r;

  // sequencer state
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [LEFT_W-1:0]     left_r, left_nxt;
  logic                  fwd_r, fwd_nxt;
  logic [INTERVAL_W-1:0] wait_r, wait_nxt;
  coil_t                 coil_r, coil_nxt;

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                  accept;
  logic                  half;
  logic [CMP_W-1:0]      base_ext, base_sat;
  logic [REV_W-1:0]      rev;
  logic [REV_W-1:0]      pos_inc;
  logic [POS_W-1:0]      pos_step;
  logic [LEFT_W-1:0]     left_dec;
  logic [INTERVAL_W-1:0] min_interval, eff_interval;
  logic                  neg;
  logic [LEFT_W-1:0]     mag, move_steps;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign half = (mode_r == MODE_HALF);

  // revolution length, base count saturated to 1..MAX then doubled for half step
  always_comb begin
    base_ext = CMP_W'(base_r);
    if (base_ext == '0) begin
      base_sat = CMP_W'(1);
    end else if (base_ext > CMP_W'(MAX_STEPS_PER_REV)) begin
      base_sat = CMP_W'(MAX_STEPS_PER_REV);
    end else begin
      base_sat = base_ext;
    end
    rev = half ? REV_W'({base_sat, 1'b0}) : REV_W'(base_sat);
  end

  // next position for one step; an out-of-range position snaps to an end
  always_comb begin
    pos_inc = REV_W'(pos_r) + REV_W'(1);
    if (fwd_r) begin
      pos_step = (pos_inc >= rev) ? '0 : pos_inc[POS_W-1:0];
    end else if (pos_r == '0 || REV_W'(pos_r) >= rev) begin
      pos_step = POS_W'(rev - REV_W'(1));
    end else begin
      pos_step = pos_r - POS_W'(1);
    end
  end

  assign left_dec     = left_r - LEFT_W'(1);
  assign min_interval = half ? INTERVAL_W'(3) : INTERVAL_W'(2);
  assign eff_interval = (interval_r < min_interval) ? min_interval : interval_r;

  assign neg        = in_tdata[MOVE_W-1];
  assign mag        = neg ? (LEFT_W'(17'h10000) - LEFT_W'(in_tdata)) : LEFT_W'(in_tdata);
  assign move_steps = half ? LEFT_W'({mag, 1'b0}) : mag;

  always_comb begin
    pos_nxt  = pos_r;
    left_nxt = left_r;
    fwd_nxt  = fwd_r;
    wait_nxt = wait_r;
    coil_nxt = coil_r;
    case (in_tuser)
      CMD_TICK: begin
        if (left_r != '0) begin
          if (wait_r == '0) begin
            pos_nxt  = pos_step;
            left_nxt = left_dec;
            coil_nxt = (left_dec == '0) ? '0 : coil_pattern(mode_r, 3'(pos_step));
            wait_nxt = eff_interval - INTERVAL_W'(1);
          end else begin
            wait_nxt = wait_r - INTERVAL_W'(1);
          end
        end
      end
      CMD_MOVE: begin
        fwd_nxt  = !neg;
        left_nxt = move_steps;
        wait_nxt = '0;
        if (move_steps == '0) coil_nxt = '0;
      end
      CMD_STOP: begin
        left_nxt = '0;
        wait_nxt = '0;
        coil_nxt = '0;
      end
      default: ;  // unknown command leaves state alone
    endcase
    out_data_nxt = OUT_DATA_W'({POS_OUT_W'(pos_nxt), (left_nxt != '0), coil_nxt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_FULL;
      base_r      <= BASE_W'(2048);
      interval_r  <= INTERVAL_W'(30);
      pos_r       <= '0;
      left_r      <= '0;
      fwd_r       <= 1'b1;
      wait_r      <= '0;
      coil_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_STEP_MODE:     mode_r     <= cfg_wdata[1:0];
          REG_BASE_STEPS:    base_r     <= cfg_wdata[BASE_W-1:0];
          REG_STEP_INTERVAL: interval_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        pos_r       <= pos_nxt;
        left_r      <= left_nxt;
        fwd_r       <= fwd_nxt;
        wait_r      <= wait_nxt;
        coil_r      <= coil_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_data_r <= out_data_nxt;
  end

endmodule
